[rtl/spp_pkg.sv]
// stride prefetch predictor: shared field widths, register map and reset values,
// and the command/status structs between controller and datapath
// no dependencies
`default_nettype none

package spp_pkg;

   localparam int BLOCK_W    = 48;
   localparam int PAGE_W     = 9;
   localparam int END_W      = 10;
   localparam int STRIDE_W   = 10;
   localparam int THR_W      = 8;
   localparam int PAGES_W    = 10;
   // signed width of the window arithmetic, covers every page count up to 4096
   localparam int WIN_W      = 14;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register word index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_STRIDE_LIMIT   = 2'd0,
      REG_CONF_THRESHOLD = 2'd1,
      REG_WINDOW_PAGES   = 2'd2,
      REG_UNUSED         = 2'd3
   } spp_reg_type;

   localparam logic [PAGE_W-1:0]  STRIDE_LIMIT_RESET   = 9'd128;
   localparam logic [THR_W-1:0]   CONF_THRESHOLD_RESET = 8'd2;
   localparam logic [PAGES_W-1:0] WINDOW_PAGES_RESET   = 10'd2;

   typedef struct packed {
      logic clear_step;  // write an empty entry at the clearing pointer
      logic capture;     // request accepted: latch fields, start table read
      logic update;      // table data present: compute and write back
      logic deliver;     // load the result register
   } spp_cmd_type;

   typedef struct packed {
      logic clear_last;  // clearing pointer at the last entry
      logic out_free;    // result register empty or being taken
   } spp_status_type;

endpackage

`default_nettype wire

[rtl/spp_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module spp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/spp_ctrl.sv]
// stride prefetch predictor controller: clearing pass, request capture,
// table update and result hand-off sequencing
// depends on spp_pkg
`default_nettype none

module spp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire spp_pkg::spp_status_type status,
   output spp_pkg::spp_cmd_type        cmd
);

   import spp_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_comb begin
      req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && status.out_free);
      accept    = req_valid && req_ready;

      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.capture    = accept;
      cmd.update     = (state_ff == ST_LOOKUP);
      cmd.deliver    = (state_ff == ST_FINISH) && status.out_free;

      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // the next request may enter while this result is loaded
            if (status.out_free) begin
               state_in = accept ? ST_LOOKUP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/spp_datapath.sv]
// stride prefetch predictor datapath: request registers, stride table ram,
// entry update logic, window clamping and the result register
// depends on spp_pkg and spp_ram
`default_nettype none

module spp_datapath #(
   parameter int TABLE_ENTRIES   = 4096,
   parameter int PAGES_PER_BLOCK = 512,
   parameter int CONFIDENCE_MAX  = 255
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire spp_pkg::spp_cmd_type          cmd,
   output spp_pkg::spp_status_type            status,
   input  wire logic [spp_pkg::BLOCK_W-1:0]   req_block_id,
   input  wire logic [spp_pkg::PAGE_W-1:0]    req_page_index,
   input  wire logic [spp_pkg::PAGE_W-1:0]    req_limit_first,
   input  wire logic [spp_pkg::END_W-1:0]     req_limit_end,
   input  wire logic [spp_pkg::PAGE_W-1:0]    stride_limit,
   input  wire logic [spp_pkg::THR_W-1:0]     confidence_threshold,
   input  wire logic [spp_pkg::PAGES_W-1:0]   window_pages,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_prefetch_valid,
   output logic      [spp_pkg::PAGE_W-1:0]    rsp_region_first,
   output logic      [spp_pkg::END_W-1:0]     rsp_region_end
);

   import spp_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int TAG_W  = BLOCK_W - IDX_W;
   localparam int CONF_W = $clog2(CONFIDENCE_MAX + 1);
   localparam int CMP_W  = (CONF_W > THR_W) ? CONF_W : THR_W;
   localparam int WORD_W = 1 + TAG_W + PAGE_W + STRIDE_W + CONF_W;
   localparam logic [CONF_W-1:0] CONF_MAX_C = CONF_W'(CONFIDENCE_MAX);

   // request registers
   logic [IDX_W-1:0]  idx_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              zero_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [PAGE_W-1:0] lim_first_ff;
   logic [END_W-1:0]  lim_end_ff;

   // update results kept for the window cycle
   logic                       issue_ff;
   logic signed [STRIDE_W-1:0] pstride_ff;

   logic [IDX_W-1:0] clr_ff;

   logic                rsp_valid_ff;
   logic                rsp_prefetch_valid_ff;
   logic [PAGE_W-1:0]   rsp_region_first_ff;
   logic [END_W-1:0]    rsp_region_end_ff;

   // table
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;

   logic                       e_valid;
   logic [TAG_W-1:0]           e_tag;
   logic [PAGE_W-1:0]          e_last;
   logic signed [STRIDE_W-1:0] e_stride;
   logic [CONF_W-1:0]          e_conf;

   logic                       hit;
   logic signed [STRIDE_W-1:0] stride;
   logic [STRIDE_W-1:0]        mag;
   logic [CONF_W-1:0]          conf_inc;
   logic [CONF_W-1:0]          conf_dec;
   logic signed [STRIDE_W-1:0] new_stride;
   logic [CONF_W-1:0]          new_conf;
   logic                       issue_in;

   // window
   logic signed [WIN_W-1:0] page_w;
   logic signed [WIN_W-1:0] stride_w;
   logic signed [WIN_W-1:0] pages_w;
   logic signed [WIN_W-1:0] lim_first_w;
   logic signed [WIN_W-1:0] lim_end_w;
   logic signed [WIN_W-1:0] ppb_w;
   logic signed [WIN_W-1:0] pred;
   logic signed [WIN_W-1:0] first;
   logic signed [WIN_W-1:0] outer;
   logic signed [WIN_W-1:0] first_c;
   logic signed [WIN_W-1:0] outer_l;
   logic signed [WIN_W-1:0] outer_c;
   logic                    region_ok;

   spp_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (cmd.capture),
      .rd_addr(req_block_id[IDX_W-1:0]),
      .rd_data(ram_rdata)
   );

   assign e_valid  = ram_rdata[WORD_W-1];
   assign e_tag    = ram_rdata[WORD_W-2 -: TAG_W];
   assign e_last   = ram_rdata[CONF_W+STRIDE_W+PAGE_W-1 -: PAGE_W];
   assign e_stride = signed'(ram_rdata[CONF_W+STRIDE_W-1 -: STRIDE_W]);
   assign e_conf   = ram_rdata[CONF_W-1:0];

   // entry update
   always_comb begin
      hit      = e_valid && (e_tag == tag_ff);
      stride   = signed'({1'b0, page_ff}) - signed'({1'b0, e_last});
      mag      = stride[STRIDE_W-1] ? unsigned'(-stride) : unsigned'(stride);
      conf_inc = (e_conf < CONF_MAX_C) ? e_conf + CONF_W'(1) : e_conf;
      conf_dec = (e_conf != '0) ? e_conf - CONF_W'(1) : e_conf;

      new_stride = e_stride;
      new_conf   = e_conf;
      issue_in   = 1'b0;
      if (!hit) begin
         new_stride = '0;
         new_conf   = '0;
      end else if (stride == '0) begin
         new_conf = e_conf;
      end else if (mag > {1'b0, stride_limit}) begin
         new_conf = conf_dec;
      end else begin
         if (stride == e_stride) begin
            new_conf = conf_inc;
         end else begin
            new_conf   = conf_dec;
            new_stride = stride;
         end
         issue_in = !zero_ff &&
                    !(CMP_W'(new_conf) < CMP_W'(confidence_threshold));
      end
   end

   // clearing pass has the write port to itself
   always_comb begin
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = cmd.update && !zero_ff;
         ram_waddr = idx_ff;
         ram_wdata = {1'b1, tag_ff, page_ff, new_stride, new_conf};
      end
   end

   // prefetch window on the stride's side of the predicted page
   always_comb begin
      page_w      = signed'({{(WIN_W-PAGE_W){1'b0}}, page_ff});
      stride_w    = signed'({{(WIN_W-STRIDE_W){pstride_ff[STRIDE_W-1]}}, pstride_ff});
      pages_w     = signed'({{(WIN_W-PAGES_W){1'b0}}, window_pages});
      lim_first_w = signed'({{(WIN_W-PAGE_W){1'b0}}, lim_first_ff});
      lim_end_w   = signed'({{(WIN_W-END_W){1'b0}}, lim_end_ff});
      ppb_w       = signed'(WIN_W'(PAGES_PER_BLOCK));

      pred = page_w + stride_w;
      if (!pstride_ff[STRIDE_W-1]) begin
         first = pred;
         outer = pred + pages_w;
      end else begin
         first = pred - pages_w + WIN_W'(1);
         outer = pred + WIN_W'(1);
      end
      first_c   = (first < lim_first_w) ? lim_first_w : first;
      outer_l   = (outer > lim_end_w) ? lim_end_w : outer;
      outer_c   = (outer_l > ppb_w) ? ppb_w : outer_l;
      region_ok = issue_ff && (first_c < outer_c);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff       <= req_block_id[IDX_W-1:0];
         tag_ff       <= req_block_id[BLOCK_W-1:IDX_W];
         zero_ff      <= (req_block_id == '0);
         page_ff      <= req_page_index;
         lim_first_ff <= req_limit_first;
         lim_end_ff   <= req_limit_end;
      end
      if (cmd.update) begin
         issue_ff   <= issue_in;
         pstride_ff <= stride;
      end
      if (cmd.deliver) begin
         rsp_prefetch_valid_ff <= region_ok;
         rsp_region_first_ff   <= region_ok ? first_c[PAGE_W-1:0] : '0;
         rsp_region_end_ff     <= region_ok ? outer_c[END_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
         if (cmd.deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = (clr_ff == {IDX_W{1'b1}});
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prefetch_valid = rsp_prefetch_valid_ff;
   assign rsp_region_first   = rsp_region_first_ff;
   assign rsp_region_end     = rsp_region_end_ff;

endmodule

`default_nettype wire

[rtl/stride_prefetch_predictor.sv]
// Stride prefetch predictor top level: configuration registers and the
// controller/datapath pair. Depends on spp_pkg, spp_ctrl, spp_datapath, spp_ram.
`default_nettype none

// Each request (a faulting block id, page index and allowed page region) looks up
// a direct-mapped table of TABLE_ENTRIES entries (a power of two), indexed by the
// low block id bits and tagged by the rest, and returns one response: a prefetch
// region when the entry hits with a nonzero stride within the stride limit and its
// confidence reaches the threshold, else an empty one. The table entry is read at
// the accepting edge, then updated and written back through the single write port,
// and then the prefetch window is clamped and the response register loaded once it
// is free; a new request can be taken in the cycle that this response is loaded.
// After reset a clearing pass writes every table entry, one a cycle; no request is
// taken until it ends, while register writes are taken at any time. Registers: 0x0
// stride limit, 0x4 confidence threshold, 0x8 window pages.
module stride_prefetch_predictor #(
   parameter int TABLE_ENTRIES   = 4096,
   parameter int PAGES_PER_BLOCK = 512,
   parameter int CONFIDENCE_MAX  = 255
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [spp_pkg::BLOCK_W-1:0]      req_block_id,
   input  wire logic [spp_pkg::PAGE_W-1:0]       req_page_index,
   input  wire logic [spp_pkg::PAGE_W-1:0]       req_limit_first,
   input  wire logic [spp_pkg::END_W-1:0]        req_limit_end,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_prefetch_valid,
   output logic      [spp_pkg::PAGE_W-1:0]       rsp_region_first,
   output logic      [spp_pkg::END_W-1:0]        rsp_region_end,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [spp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [spp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [spp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   import spp_pkg::*;

   logic [PAGE_W-1:0]  stride_limit_ff;
   logic [THR_W-1:0]   conf_threshold_ff;
   logic [PAGES_W-1:0] window_pages_ff;
   logic               csr_write;
   spp_reg_type        csr_reg;

   spp_cmd_type    cmd;
   spp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_reg    = spp_reg_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_limit_ff   <= STRIDE_LIMIT_RESET;
         conf_threshold_ff <= CONF_THRESHOLD_RESET;
         window_pages_ff   <= WINDOW_PAGES_RESET;
      end else if (csr_write) begin
         case (csr_reg)
            REG_STRIDE_LIMIT: begin
               stride_limit_ff <= csr_pwdata[PAGE_W-1:0];
            end
            REG_CONF_THRESHOLD: begin
               conf_threshold_ff <= csr_pwdata[THR_W-1:0];
            end
            REG_WINDOW_PAGES: begin
               window_pages_ff <= csr_pwdata[PAGES_W-1:0];
            end
            default: begin
               stride_limit_ff <= stride_limit_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_STRIDE_LIMIT: begin
            csr_prdata = CSR_DATA_W'(stride_limit_ff);
         end
         REG_CONF_THRESHOLD: begin
            csr_prdata = CSR_DATA_W'(conf_threshold_ff);
         end
         REG_WINDOW_PAGES: begin
            csr_prdata = CSR_DATA_W'(window_pages_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   spp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   spp_datapath #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
      .CONFIDENCE_MAX (CONFIDENCE_MAX)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_block_id        (req_block_id),
      .req_page_index      (req_page_index),
      .req_limit_first     (req_limit_first),
      .req_limit_end       (req_limit_end),
      .stride_limit        (stride_limit_ff),
      .confidence_threshold(conf_threshold_ff),
      .window_pages        (window_pages_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_prefetch_valid  (rsp_prefetch_valid),
      .rsp_region_first    (rsp_region_first),
      .rsp_region_end      (rsp_region_end)
   );

endmodule

`default_nettype wire
